[hw/rtl/rwbc_pkg.sv]
// Shared constants and types for the register write burst coalescer.
`timescale 1ns / 1ps
package rwbc_pkg;

    localparam int ADDR_WIDTH_DEF = 16;
    localparam int BYTE_WIDTH     = 8;
    localparam int TUSER_WIDTH    = 3;
    localparam int FIFO_DEPTH     = 4;

    // tuser bit positions on the result side
    localparam int TUSER_IS_BURST  = 0;
    localparam int TUSER_RUN_START = 1;
    localparam int TUSER_RUN_END   = 2;

    // Results produced by the core for one pair
    typedef struct packed {
        logic push_first;
        logic push_second;
    } push_t;

endpackage

[hw/rtl/rwbc_core.sv]
// Hold-back state and result formation for one pair per cycle.
`timescale 1ns / 1ps
module rwbc_core #(
    parameter int ADDR_WIDTH = rwbc_pkg::ADDR_WIDTH_DEF,
    parameter int TDATA_W    = 40,
    parameter int ENT_W      = 44
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  item_valid,
    input  logic                  item_take,
    input  logic [ADDR_WIDTH-1:0] item_addr,
    input  logic [7:0]            item_byte,
    input  logic                  item_last,
    output rwbc_pkg::push_t       push,
    output logic [ENT_W-1:0]      first_entry,
    output logic [ENT_W-1:0]      second_entry
);
    import rwbc_pkg::*;

    logic                  held_valid_reg, held_valid_next;
    logic [ADDR_WIDTH-1:0] held_addr_reg, held_addr_next;
    logic [7:0]            held_byte_reg, held_byte_next;
    logic                  in_run_reg, in_run_next;
    logic [ADDR_WIDTH-1:0] burst_base_reg, burst_base_next;

    logic                  joins;
    logic                  run_a;
    logic [ADDR_WIDTH-1:0] base_a;
    logic [ENT_W-1:0]      entry_a, entry_b;

    function automatic logic [ENT_W-1:0] pack_entry(
        input logic [ADDR_WIDTH-1:0] addr,
        input logic [7:0]            data,
        input logic                  burst,
        input logic [ADDR_WIDTH-1:0] base,
        input logic                  start,
        input logic                  stop,
        input logic                  done
    );
        logic [ENT_W-1:0] e;
        e = '0;
        e[ADDR_WIDTH-1:0]                    = addr;
        e[ADDR_WIDTH+7:ADDR_WIDTH]           = data;
        e[2*ADDR_WIDTH+7:ADDR_WIDTH+8]       = base;
        e[TDATA_W+TUSER_IS_BURST]            = burst;
        e[TDATA_W+TUSER_RUN_START]           = start;
        e[TDATA_W+TUSER_RUN_END]             = stop;
        e[TDATA_W+TUSER_WIDTH]               = done;
        return e;
    endfunction

    always_comb begin
        joins = held_valid_reg && (held_addr_reg != {ADDR_WIDTH{1'b1}}) &&
                (item_addr == ADDR_WIDTH'(held_addr_reg + 1'b1));
        run_a  = joins;
        base_a = (joins && !in_run_reg) ? held_addr_reg : burst_base_reg;

        entry_a = pack_entry(held_addr_reg, held_byte_reg, joins || in_run_reg,
                             (joins || in_run_reg) ? base_a : held_addr_reg,
                             joins && !in_run_reg, !joins && in_run_reg, 1'b0);
        entry_b = pack_entry(item_addr, item_byte, run_a,
                             run_a ? base_a : item_addr, 1'b0, run_a, 1'b1);

        push.push_first  = item_valid && (held_valid_reg || item_last);
        push.push_second = item_valid && held_valid_reg && item_last;
        first_entry      = held_valid_reg ? entry_a : entry_b;
        second_entry     = entry_b;

        held_valid_next = held_valid_reg;
        held_addr_next  = held_addr_reg;
        held_byte_next  = held_byte_reg;
        in_run_next     = in_run_reg;
        burst_base_next = burst_base_reg;
        if (item_take) begin
            if (item_last) begin
                // flush: back to the idle state for the next list
                held_valid_next = 1'b0;
                held_addr_next  = '0;
                held_byte_next  = '0;
                in_run_next     = 1'b0;
                burst_base_next = '0;
            end else begin
                held_valid_next = 1'b1;
                held_addr_next  = item_addr;
                held_byte_next  = item_byte;
                in_run_next     = run_a;
                burst_base_next = base_a;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg <= 1'b0;
            held_addr_reg  <= '0;
            held_byte_reg  <= '0;
            in_run_reg     <= 1'b0;
            burst_base_reg <= '0;
        end else begin
            held_valid_reg <= held_valid_next;
            held_addr_reg  <= held_addr_next;
            held_byte_reg  <= held_byte_next;
            in_run_reg     <= in_run_next;
            burst_base_reg <= burst_base_next;
        end
    end

    a_run_needs_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_run_reg |-> held_valid_reg)
        else $error("run open without a held pair");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_take && item_last) |=> (!held_valid_reg && !in_run_reg))
        else $error("final pair did not flush the held state");

    a_start_end_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        push.push_first |-> !(first_entry[TDATA_W+TUSER_RUN_START] &&
                              first_entry[TDATA_W+TUSER_RUN_END]))
        else $error("burst start and end on the same beat");

endmodule

[hw/rtl/rwbc_out_fifo.sv]
// Small result queue: takes up to two entries per cycle, drains one while out_ready is high.
`timescale 1ns / 1ps
module rwbc_out_fifo #(
    parameter int ENT_W = 44
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  rwbc_pkg::push_t   push,
    input  logic [ENT_W-1:0]  first_entry,
    input  logic [ENT_W-1:0]  second_entry,
    output logic              room_two,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ENT_W-1:0]  out_entry
);
    import rwbc_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [ENT_W-1:0] slot_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;
    logic [1:0]       push_n;

    always_comb begin
        pop       = out_valid && out_ready;
        push_n    = {1'b0, push.push_first} + {1'b0, push.push_second};
        room_two  = count_reg <= CNT_W'(FIFO_DEPTH - 2);
        out_valid = count_reg != '0;
        out_entry = slot_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push_n) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.push_first) begin
            slot_reg[wr_ptr_reg] <= first_entry;
        end
        if (push.push_second) begin
            slot_reg[wr_ptr_reg + PTR_W'(1)] <= second_entry;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push.push_second |-> push.push_first)
        else $error("second result pushed without a first");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != CNT_W'(FIFO_DEPTH)) |->
        (PTR_W'(wr_ptr_reg - rd_ptr_reg) == PTR_W'(count_reg)))
        else $error("queue pointers disagree with fill count");

endmodule

[hw/rtl/register_write_burst_coalescer_unit.sv]
// Top level of the register write burst coalescer.
// Results: a pair's result is queued when the next pair (or its own final mark) is taken;
// the final pair adds its own flushed result in the same queue push.
// Throughput: one pair per cycle while the queue has room for two; a list's first pair
// yields none and a later final pair two, so results also average one beat per cycle.
// Reset: aresetn synchronous active low empties the input register, the held pair and
// the four-entry result queue.
`timescale 1ns / 1ps
module register_write_burst_coalescer_unit #(
    parameter int ADDR_WIDTH = rwbc_pkg::ADDR_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // reg_addr, data_byte, zero pad
    input  logic [((ADDR_WIDTH+15)/8)*8-1:0]      s_tdata,
    input  logic                                  s_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // out_addr, out_byte, run_base, zero pad
    output logic [((2*ADDR_WIDTH+15)/8)*8-1:0]    m_tdata,
    // is_burst, run_start, run_end
    output logic [rwbc_pkg::TUSER_WIDTH-1:0]      m_tuser,
    output logic                                  m_tlast
);
    import rwbc_pkg::*;

    localparam int TDATA_W = ((2*ADDR_WIDTH+15)/8)*8;
    localparam int ENT_W   = TDATA_W + TUSER_WIDTH + 1;

    logic                  in_valid_reg;
    logic [ADDR_WIDTH-1:0] in_addr_reg;
    logic [7:0]            in_byte_reg;
    logic                  in_last_reg;
    logic                  room_two;
    logic                  take;
    push_t                 push;
    logic [ENT_W-1:0]      first_entry, second_entry, out_entry;

    // advance the held beat only when the queue can absorb both results
    assign take     = in_valid_reg && room_two;
    assign s_tready = !in_valid_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_addr_reg <= s_tdata[ADDR_WIDTH-1:0];
            in_byte_reg <= s_tdata[ADDR_WIDTH+7:ADDR_WIDTH];
            in_last_reg <= s_tlast;
        end
    end

    rwbc_core #(
        .ADDR_WIDTH (ADDR_WIDTH),
        .TDATA_W    (TDATA_W),
        .ENT_W      (ENT_W)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_valid   (take),
        .item_take    (take),
        .item_addr    (in_addr_reg),
        .item_byte    (in_byte_reg),
        .item_last    (in_last_reg),
        .push         (push),
        .first_entry  (first_entry),
        .second_entry (second_entry)
    );

    rwbc_out_fifo #(
        .ENT_W (ENT_W)
    ) u_out_fifo (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push         (push),
        .first_entry  (first_entry),
        .second_entry (second_entry),
        .room_two     (room_two),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_entry    (out_entry)
    );

    assign m_tdata = out_entry[TDATA_W-1:0];
    assign m_tuser = out_entry[TDATA_W+TUSER_WIDTH-1:TDATA_W];
    assign m_tlast = out_entry[TDATA_W+TUSER_WIDTH];

    a_take_needs_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        take |-> in_valid_reg)
        else $error("core advanced without a held input beat");

    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> in_valid_reg)
        else $error("accepted beat lost from the input register");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !take) |=> (in_valid_reg && $stable(in_addr_reg)))
        else $error("stalled input register changed");

endmodule

[dv/register_write_burst_coalescer_checker.sv]
// Checker for the burst coalescer: predicts the coalesced writes and compares result beats.
`timescale 1ns / 1ps
module register_write_burst_coalescer_checker #(
    parameter int AW = rwbc_pkg::ADDR_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [((AW+15)/8)*8-1:0]       s_tdata,
    input  logic                           s_tlast,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [((2*AW+15)/8)*8-1:0]     m_tdata,
    input  logic [rwbc_pkg::TUSER_WIDTH-1:0] m_tuser,
    input  logic                           m_tlast,
    output int                             mismatch_count,
    output int                             pending_writes
);
    import rwbc_pkg::*;

    localparam logic [AW-1:0] TOP_ADDR = '1;

    typedef struct packed {
        logic [AW-1:0] addr;
        logic [7:0]    data;
        logic          burst;
        logic [AW-1:0] base;
        logic          run_start;
        logic          run_end;
        logic          done;
    } reg_write_t;

    reg_write_t    expected_writes[$];

    // one pair waits here until the next one shows whether it joins a burst
    logic          pend_valid;
    logic [AW-1:0] pend_addr;
    logic [7:0]    pend_byte;
    logic          bursting;
    logic [AW-1:0] open_run_addr;

    task automatic coalesce_pair(input logic [AW-1:0] a, input logic [7:0] d,
                                 input logic ends_list);
        reg_write_t w;
        logic       joins;
        if (pend_valid) begin
            joins = (pend_addr != TOP_ADDR) && (a == pend_addr + 1'b1);
            if (joins) begin
                if (!bursting) begin
                    open_run_addr = pend_addr;
                end
                w = '{pend_addr, pend_byte, 1'b1, open_run_addr, !bursting, 1'b0, 1'b0};
                bursting = 1'b1;
            end else if (bursting) begin
                w = '{pend_addr, pend_byte, 1'b1, open_run_addr, 1'b0, 1'b1, 1'b0};
                bursting = 1'b0;
            end else begin
                w = '{pend_addr, pend_byte, 1'b0, pend_addr, 1'b0, 1'b0, 1'b0};
            end
            expected_writes.insert(expected_writes.size(), w);
        end
        pend_valid = 1'b1;
        pend_addr  = a;
        pend_byte  = d;
        if (ends_list) begin
            // flush the new pair and return to the idle state
            if (bursting) begin
                w = '{a, d, 1'b1, open_run_addr, 1'b0, 1'b1, 1'b1};
            end else begin
                w = '{a, d, 1'b0, a, 1'b0, 1'b0, 1'b1};
            end
            expected_writes.insert(expected_writes.size(), w);
            pend_valid    = 1'b0;
            pend_addr     = '0;
            pend_byte     = '0;
            bursting      = 1'b0;
            open_run_addr = '0;
        end
    endtask

    task automatic check_write(input reg_write_t got);
        reg_write_t want;
        if (expected_writes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("%0t: unexpected write addr=%h byte=%h burst=%b base=%h ",
                         $realtime, got.addr, got.data, got.burst, got.base,
                         "start=%b end=%b done=%b",
                         got.run_start, got.run_end, got.done);
            end
        end else begin
            want = expected_writes.pop_front();
            if (got.addr !== want.addr || got.data !== want.data ||
                    got.burst !== want.burst || got.base !== want.base ||
                    got.run_start !== want.run_start || got.run_end !== want.run_end ||
                    got.done !== want.done) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("%0t: write mismatch, expected addr=%h byte=%h burst=%b ",
                             $realtime, want.addr, want.data, want.burst,
                             "base=%h start=%b end=%b done=%b",
                             want.base, want.run_start, want.run_end, want.done);
                    $display("    actual addr=%h byte=%h burst=%b base=%h ",
                             got.addr, got.data, got.burst, got.base,
                             "start=%b end=%b done=%b",
                             got.run_start, got.run_end, got.done);
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_writes.delete();
            pend_valid     = 1'b0;
            pend_addr      = '0;
            pend_byte      = '0;
            bursting       = 1'b0;
            open_run_addr  = '0;
            mismatch_count = 0;
        end else begin
            // results at this edge come from pairs accepted earlier
            if (m_tvalid && m_tready) begin
                check_write('{m_tdata[AW-1:0], m_tdata[AW+7:AW], m_tuser[TUSER_IS_BURST],
                              m_tdata[2*AW+7:AW+8], m_tuser[TUSER_RUN_START],
                              m_tuser[TUSER_RUN_END], m_tlast});
            end
            if (s_tvalid && s_tready) begin
                coalesce_pair(s_tdata[AW-1:0], s_tdata[AW+7:AW], s_tlast);
            end
        end
        pending_writes = expected_writes.size();
    end

endmodule

[dv/register_write_burst_coalescer_unit_test.sv]
// Top of the burst coalescer testbench: clock, reset, pair stimulus, sink stalls, verdict.
`timescale 1ns / 1ps
module register_write_burst_coalescer_unit_test;
    import rwbc_pkg::*;

    localparam int AW          = ADDR_WIDTH_DEF;
    localparam int SW          = ((AW + 15) / 8) * 8;
    localparam int MW          = ((2 * AW + 15) / 8) * 8;
    localparam int TOP_ADDR    = (1 << AW) - 1;
    localparam int STALL_LIMIT = 4000;
    localparam int PAIR_COUNT  = 1200;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [SW-1:0]          s_tdata;   // reg_addr, data_byte, zero pad
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [MW-1:0]          m_tdata;   // out_addr, out_byte, run_base, zero pad
    logic [TUSER_WIDTH-1:0] m_tuser;   // is_burst, run_start, run_end
    logic                   m_tlast;

    int mismatch_count;
    int pending_writes;
    int pairs_sent;
    int quiet_cycles;
    bit src_gaps;
    bit sink_stalls;

    register_write_burst_coalescer_unit #(.ADDR_WIDTH(AW)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    register_write_burst_coalescer_checker #(.AW(AW)) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .mismatch_count(mismatch_count),
        .pending_writes(pending_writes)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    task automatic send_pair(input logic [AW-1:0] a, input logic [7:0] d, input logic ends);
        logic [SW-1:0] beat;
        beat            = '0;
        beat[AW-1:0]    = a;
        beat[AW+7:AW]   = d;
        if (src_gaps && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        s_tlast  <= ends;
        do @(posedge aclk); while (!s_tready);
        pairs_sent++;
    endtask

    // hold the sender until every predicted write has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_writes != 0);
    endtask

    task automatic send_random_list(input int len, input int pause_at);
        logic [AW-1:0] a;
        int            pick;
        a = AW'($urandom);
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 15);
            if (i == 0) begin
                pick = 0;
            end
            case (pick) inside
                [0:2]:   a = AW'($urandom);
                3:       a = AW'($urandom_range(TOP_ADDR - 3, TOP_ADDR));
                4:       ;  // repeat the address
                5:       a = a - 1'b1;
                default: a = a + 1'b1;
            endcase
            if (i == pause_at) begin
                wait_drained();
            end
            send_pair(a, 8'($urandom), i == len - 1);
        end
    endtask

    // sink side: random stall bursts while allowed
    initial begin
        m_tready = 1'b0;
        forever begin
            if (sink_stalls && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    // watchdog on cycles without any accepted beat
    initial begin
        quiet_cycles = 0;
        do begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end while (quiet_cycles < STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int len;
        bit paused;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        aresetn     = 1'b0;
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        pairs_sent  = 0;
        paused      = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // a list of one pair
        send_pair(16'h0000, 8'h00, 1'b1);
        // burst that ends on the top address
        send_pair(16'hFFFE, 8'hFF, 1'b0);
        send_pair(16'hFFFF, 8'h00, 1'b1);
        // top address must not join with address zero
        send_pair(16'hFFFF, 8'hAA, 1'b0);
        send_pair(16'h0000, 8'h55, 1'b1);
        // single, burst of three, repeated address, descending address
        send_pair(16'h1234, 8'hA5, 1'b0);
        send_pair(16'h0010, 8'h5A, 1'b0);
        send_pair(16'h0011, 8'hC3, 1'b0);
        send_pair(16'h0012, 8'h3C, 1'b0);
        send_pair(16'h0100, 8'h01, 1'b0);
        send_pair(16'h0100, 8'h80, 1'b0);
        send_pair(16'h00FF, 8'h7F, 1'b0);
        send_pair(16'h0100, 8'hFE, 1'b0);
        send_pair(16'hAAAA, 8'h96, 1'b1);
        // burst across a carry that the final pair closes
        send_pair(16'h7FFF, 8'h69, 1'b0);
        send_pair(16'h8000, 8'h0F, 1'b0);
        send_pair(16'h8001, 8'hF0, 1'b1);
        // two bursts back to back, then a single on the top address
        send_pair(16'h5554, 8'h11, 1'b0);
        send_pair(16'h5555, 8'h22, 1'b0);
        send_pair(16'h2000, 8'h33, 1'b0);
        send_pair(16'h2001, 8'h44, 1'b0);
        send_pair(16'hFFFF, 8'hFF, 1'b1);
        wait_drained();

        while (pairs_sent < PAIR_COUNT) begin
            src_gaps    = pairs_sent < 300 || (pairs_sent >= 600 && pairs_sent < 900);
            sink_stalls = pairs_sent < 600;
            if (pairs_sent >= 1000) begin
                src_gaps    = 1'b0;
                sink_stalls = 1'b0;
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
            if (!paused && pairs_sent >= 500 && len > 2) begin
                paused = 1'b1;
                send_random_list(len, len / 2);
            end else begin
                send_random_list(len, -1);
            end
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && pending_writes == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[register_write_burst_coalescer_unit.f]
hw/rtl/rwbc_pkg.sv
hw/rtl/rwbc_core.sv
hw/rtl/rwbc_out_fifo.sv
hw/rtl/register_write_burst_coalescer_unit.sv
dv/register_write_burst_coalescer_checker.sv
dv/register_write_burst_coalescer_unit_test.sv
